@@ design/sfq_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Supernormal float quantizer package
// Shared constants and the register index codes of the configuration port.
// ---------------------------------------------------------------------------
package sfq_pkg;
	localparam int unsigned CfgDataW = 5;
	localparam int unsigned CfgIdxW  = 1;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MANTISSA_BITS = 1'b0,
		REG_EXPONENT_BITS = 1'b1
	} cfg_reg_t;

	localparam logic [31:0] SignMask = 32'h8000_0000;
	localparam logic [31:0] InfBits  = 32'h7F80_0000;
	localparam logic [31:0] MantMask = 32'h007F_FFFF;
	localparam logic [31:0] HalfMant = 32'h0040_0000;
	localparam logic [7:0]  ExpMax   = 8'hFF;
endpackage
`default_nettype wire

@@ design/supernormal_float_quantizer.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// Supernormal float quantizer
// Rounds single-precision bit patterns to a minifloat grid, returned as
// single-precision bit patterns.
// ---------------------------------------------------------------------------
// Channel   Handshake                  Payload
// in        in_valid / in_ready        value_bits  [31:0]
// out       out_valid / out_ready      result_bits [31:0]
// cfg       cfg_we                     cfg_index, cfg_data [4:0]
//
// An input passes the stage 1, stage 2 and output registers before its
// result is offered; one transaction is taken every cycle while the output
// is taken. The three stages are bounds, classify, round; a stall freezes every
// stage together (global enable from the output stage), so nothing is lost.
// Reset clears the valid bits and loads the register reset values.
// ---------------------------------------------------------------------------
module supernormal_float_quantizer import sfq_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [31:0]         value_bits,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [31:0]              result_bits,
	input  wire logic                cfg_we,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [CfgDataW-1:0] cfg_data
);
	typedef enum logic [1:0] {K_ZERO, K_POW2, K_INF, K_PASS} kind_t;

	logic [4:0] mant_q;
	logic [3:0] expo_q;
	logic       adv;

	// The whole pipeline moves when the output register is free or taken.
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mant_q <= 5'd3;
			expo_q <= 4'd4;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MANTISSA_BITS: mant_q <= cfg_data;
				REG_EXPONENT_BITS: expo_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Stage 1: saturate the widths and work out the exponent bounds.
	logic [4:0] m_c;
	logic [3:0] e_c;
	logic signed [10:0] ex_c, emax_c, emin_c, span_c;
	always_comb begin
		m_c    = (mant_q > 5'd22) ? 5'd22 : mant_q;
		e_c    = (expo_q < 4'd2) ? 4'd2 : ((expo_q > 4'd8) ? 4'd8 : expo_q);
		ex_c   = $signed({3'b0, value_bits[30:23]}) - 11'sd127;
		emax_c = $signed(11'(11'd1 << (e_c - 4'd1))) - 11'sd1;
		emin_c = 11'sd1 - emax_c;
		// A span of 255 already puts both extended bounds beyond every possible
		// exponent, and it keeps the bound sums inside eleven signed bits.
		span_c = (m_c > 5'd9) ? 11'sd255 : $signed(11'(11'd1 << m_c)) - 11'sd1;
	end

	logic        v_s1;
	logic [31:0] x_s1;
	logic [4:0]  m_s1;
	logic signed [10:0] ex_s1, emax_s1, emin_s1, span_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= value_bits; m_s1 <= m_c; ex_s1 <= ex_c;
			emax_s1 <= emax_c; emin_s1 <= emin_c; span_s1 <= span_c;
		end
	end

	// Stage 2: classify and prepare the even rounding mask and addend.
	kind_t       kind_c;
	logic        norm_c;
	logic [23:0] lowmask_c;
	logic [22:0] half_c;
	logic [31:0] x2;
	always_comb begin
		x2     = x_s1;
		norm_c = 1'b0;
		if (ex_s1 < emin_s1)
			kind_c = (ex_s1 < emin_s1 - span_s1) ? K_ZERO : K_POW2;
		else if (ex_s1 > emax_s1) begin
			if (ex_s1 == 11'sd128) kind_c = K_PASS;
			else if (ex_s1 > emax_s1 + span_s1) kind_c = K_INF;
			else kind_c = K_POW2;
		end else begin
			kind_c = K_PASS;
			norm_c = 1'b1;
		end
		// drop = 23 - m is 1..23
		half_c    = 23'(23'd1 << (5'd22 - m_s1));
		lowmask_c = 24'(24'hFF_FFFF >> m_s1);
		if (kind_c == K_POW2) x2 = x_s1 + HalfMant;
	end

	logic        v_s2, norm_s2;
	kind_t       kind_s2;
	logic [31:0] x_s2, xr_s2;
	logic        tie_s2;
	logic [22:0] half_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2 <= kind_c; norm_s2 <= norm_c; x_s2 <= x_s1; xr_s2 <= x2;
			half_s2 <= half_c;
			tie_s2  <= ((x_s1[23:0] & lowmask_c) == {1'b0, half_c});
		end
	end

	// Stage 3: round and assemble the result.
	logic [31:0] r_c, sum_c, mask_c;
	always_comb begin
		sum_c  = x_s2 + {9'b0, half_s2};
		// mask = 2^(drop+tie)-1 = (half<<1)-1, widened once more on a tie
		mask_c = tie_s2 ? ({8'b0, half_s2, 1'b0} << 1) - 32'd1
		                : {8'b0, half_s2, 1'b0} - 32'd1;
		case (kind_s2)
			K_ZERO:  r_c = 32'd0;
			K_POW2:  r_c = xr_s2 & ~MantMask;
			K_INF:   r_c = (x_s2 & SignMask) | InfBits;
			K_PASS:  r_c = norm_s2 ? (sum_c & ~mask_c) : x_s2;
			default: r_c = x_s2;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) result_bits <= r_c;
	end

	// A stalled output must keep its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_bits))
		else $error("output changed during stall");
	// Underflowed results are always positive zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s2 && kind_s2 == K_ZERO |=> result_bits == 32'd0)
		else $error("underflow not zero");
	// Overflowed results carry an infinite exponent field.
	a_inf: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s2 && kind_s2 == K_INF |=> result_bits[30:23] == ExpMax)
		else $error("overflow not infinite");
endmodule
`default_nettype wire
